>>> sv/tlf_pkg.sv
// ----------------------------------------------------------------------------
// tlf_pkg
// Shared types, character codes and default sizes for the text line folder.
// ----------------------------------------------------------------------------
package tlf_pkg;

  localparam int DEF_LINE_WIDTH = 32;
  localparam int DEF_TAB_STOP   = 8;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_BLANK = 8'd32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAB,
    ST_CUT,
    ST_EMIT,
    ST_SHIFT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_char;
    logic store_blank;
    logic load_nl;
    logic load_full;
    logic load_cut;
    logic emit_char;
    logic emit_nl;
    logic shift_move;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tab;
    logic is_nl;
    logic line_empty;
    logic line_last;
    logic tab_stop_next;
    logic emit_done;
    logic shift_done;
    logic do_shift;
    logic out_free;
  } status_t;

endpackage

>>> sv/tlf_ram.sv
// ----------------------------------------------------------------------------
// tlf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tlf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> sv/tlf_datapath.sv
// ----------------------------------------------------------------------------
// tlf_datapath
// Line store, fill count, tab phase, last-blank tracker, emit pointer and
// the output register.
// ----------------------------------------------------------------------------
module tlf_datapath import tlf_pkg::*; #(
  parameter int LINE_WIDTH = DEF_LINE_WIDTH,
  parameter int TAB_STOP   = DEF_TAB_STOP
) (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  output status_t    status,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_of_run
);

  localparam int CW = $clog2(LINE_WIDTH);
  localparam int LW = $clog2(LINE_WIDTH + 1);
  localparam int PW = $clog2(TAB_STOP + 1);

  logic [CW-1:0] count, count_next;
  logic [PW-1:0] phase, phase_next;
  logic [CW-1:0] blank_pos, blank_pos_next;
  logic          blank_found, blank_found_next;
  logic [LW-1:0] idx, idx_next;
  logic [LW-1:0] cut, cut_next;
  logic          do_shift, do_shift_next;

  logic          wr_en;
  logic [7:0]    wr_data;
  logic [7:0]    rd_data;
  logic          out_free;

  assign wr_en = cmd.store_char | cmd.store_blank | cmd.shift_move;

  always_comb begin
    if (cmd.store_char) begin
      wr_data = in_char;
    end else if (cmd.store_blank) begin
      wr_data = CH_BLANK;
    end else begin
      wr_data = rd_data;
    end
  end

  // The read address runs one step ahead, so rd_data always holds store[idx].
  tlf_ram #(
    .WIDTH (8),
    .DEPTH (LINE_WIDTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count),
    .wr_data (wr_data),
    .rd_addr (idx_next[CW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    count_next       = count;
    phase_next       = phase;
    blank_pos_next   = blank_pos;
    blank_found_next = blank_found;
    idx_next         = idx;
    cut_next         = cut;
    do_shift_next    = do_shift;

    if (wr_en) begin
      count_next = count + CW'(1);
      phase_next = (phase == PW'(TAB_STOP - 1)) ? '0 : phase + PW'(1);
      // A blank in column zero never serves as a break point.
      if (wr_data == CH_BLANK && count != '0) begin
        blank_pos_next   = count;
        blank_found_next = 1'b1;
      end
    end

    if (cmd.load_nl) begin
      cut_next      = LW'(count);
      idx_next      = '0;
      do_shift_next = 1'b0;
    end
    if (cmd.load_full) begin
      cut_next      = LW'(LINE_WIDTH);
      idx_next      = '0;
      do_shift_next = 1'b0;
    end
    if (cmd.load_cut) begin
      cut_next      = blank_found ? LW'(blank_pos) + LW'(1) : LW'(LINE_WIDTH);
      idx_next      = '0;
      // A blank in the last column cuts at full width and leaves nothing to move.
      do_shift_next = blank_found && (blank_pos != CW'(LINE_WIDTH - 1));
    end
    if (cmd.emit_char || cmd.shift_move) begin
      idx_next = idx + LW'(1);
    end
    if (cmd.emit_nl) begin
      count_next       = '0;
      phase_next       = '0;
      blank_found_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      phase       <= '0;
      blank_found <= 1'b0;
    end else begin
      count       <= count_next;
      phase       <= phase_next;
      blank_found <= blank_found_next;
    end
    blank_pos <= blank_pos_next;
    idx       <= idx_next;
    cut       <= cut_next;
    do_shift  <= do_shift_next;
  end

  // Output register; a new character loads only when the slot is free.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_char || cmd.emit_nl) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_char) begin
      out_char    <= rd_data;
      last_of_run <= 1'b0;
    end else if (cmd.emit_nl) begin
      out_char    <= CH_NL;
      last_of_run <= 1'b1;
    end
  end

  always_comb begin
    status.is_tab        = (in_char == CH_TAB);
    status.is_nl         = (in_char == CH_NL);
    status.line_empty    = (count == '0);
    status.line_last     = (count == CW'(LINE_WIDTH - 1));
    status.tab_stop_next = (phase == PW'(TAB_STOP - 1));
    status.emit_done     = (idx == cut);
    status.shift_done    = (idx == LW'(LINE_WIDTH - 1));
    status.do_shift      = do_shift;
    status.out_free      = out_free;
  end

endmodule

>>> sv/tlf_ctrl.sv
// ----------------------------------------------------------------------------
// tlf_ctrl
// Sequencer for the folder: accept, tab fill, cut, emit and shift.
// ----------------------------------------------------------------------------
module tlf_ctrl import tlf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.is_tab) begin
            state_next = ST_TAB;
          end else if (status.is_nl) begin
            if (!status.line_empty) begin
              state_next = ST_EMIT;
            end
          end else if (status.line_last) begin
            state_next = ST_CUT;
          end
        end
      end
      ST_TAB: begin
        if (status.line_last) begin
          state_next = ST_EMIT;
        end else if (status.tab_stop_next) begin
          state_next = ST_IDLE;
        end
      end
      ST_CUT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.emit_done) begin
          state_next = status.do_shift ? ST_SHIFT : ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (status.shift_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !status.is_tab) begin
          if (status.is_nl) begin
            cmd.load_nl = !status.line_empty;
          end else begin
            cmd.store_char = 1'b1;
          end
        end
      end
      ST_TAB: begin
        cmd.store_blank = 1'b1;
        cmd.load_full   = status.line_last;
      end
      ST_CUT: begin
        cmd.load_cut = 1'b1;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_char = !status.emit_done;
          cmd.emit_nl   = status.emit_done;
        end
      end
      ST_SHIFT: begin
        cmd.shift_move = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> sv/text_line_folder.sv
// ----------------------------------------------------------------------------
// text_line_folder
// Folds a byte stream into lines of at most LINE_WIDTH characters.
// ----------------------------------------------------------------------------
// One character enters on the input channel (in_valid, in_stall, in_char)
// and is accepted when in_valid is high and in_stall is low. Each item
// yields zero or more output characters (out_valid, out_stall, out_char,
// last_of_run); last_of_run marks the final character caused by an item.
// An ordinary character that does not fill the line is stored at once, and
// the block is ready for the next one. A tab stores blanks up to the next
// tab stop or the end of the line. A newline or a full line streams the
// stored text at one character per cycle out of the line RAM while the
// receiver does not stall, then a newline; a line broken at a blank then
// moves its remaining text to the front of the RAM at one character per
// cycle. The output register lets the block take the next item while the
// last character still waits. When the receiver stalls, the output holds
// and emission pauses. Reset empties the line; the RAM contents are not
// cleared, and a partial line is never flushed.
// ----------------------------------------------------------------------------
module text_line_folder import tlf_pkg::*; #(
  parameter int LINE_WIDTH = DEF_LINE_WIDTH,
  parameter int TAB_STOP   = DEF_TAB_STOP
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       last_of_run
);

  cmd_t    cmd;
  status_t status;

  tlf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tlf_datapath #(
    .LINE_WIDTH (LINE_WIDTH),
    .TAB_STOP   (TAB_STOP)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_char     (in_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

endmodule

>>> verif/text_line_folder_test.sv
// ----------------------------------------------------------------------------
// text_line_folder_test
// Self-checking testbench for the text line folder.
// ----------------------------------------------------------------------------
// A short table of directed characters covers empty lines, extreme bytes,
// tabs that fill a line and a line broken at a blank. A long run of random
// text follows: words, blanks, tabs, newlines, words longer than a line,
// lines that start with a blank, and raw noise bytes. Each accepted item is
// folded by a predictor in the bench, and every output character is checked
// in order against the expected characters it produced. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module text_line_folder_test;
  import tlf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LW = DEF_LINE_WIDTH;
  localparam int TS = DEF_TAB_STOP;
  localparam int RANDOM_ITEMS = 270;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } folded_char_t;

  // n_out is the number of output characters the row must cause, or -1
  // where the predictor alone decides.
  typedef struct {
    logic [7:0] ch;
    int         n_out;
  } text_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char;
  logic       last_of_run;

  // Predictor state: the line being built and its length.
  logic [7:0]   line_mem [LW];
  int unsigned  line_len = 0;
  folded_char_t folded_q [$];
  int           n_errors = 0;
  int           steady_left = 0;
  int           stall_left = 0;
  int           quiet_left = 0;

  text_row_t text_tab [24] = '{
    '{CH_NL,    0},   // empty line gives nothing
    '{8'h00,    0},
    '{8'hFF,    0},
    '{CH_NL,    3},
    '{CH_TAB,   0},
    '{CH_TAB,   0},
    '{CH_TAB,   0},
    '{CH_TAB,   LW + 1},  // four tabs fill the line with blanks
    '{CH_NL,    0},
    '{CH_TAB,   0},
    '{CH_TAB,   0},
    '{CH_TAB,   0},
    '{8'h41,    0},
    '{8'h42,    0},
    '{8'h43,    0},
    '{8'h44,    0},
    '{8'h45,    0},
    '{8'h46,    0},
    '{8'h47,    0},
    '{8'h7E,    -1},  // line breaks after the last tab blank
    '{CH_NL,    -1},
    '{CH_BLANK, 0},
    '{8'h78,    0},
    '{CH_NL,    3}
  };

  text_line_folder #(
    .LINE_WIDTH (LW),
    .TAB_STOP   (TS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void emit_cols(input int unsigned cols);
    for (int i = 0; i < cols; i++) folded_q.push_back('{line_mem[i], 1'b0});
    if (cols > 0) folded_q.push_back('{CH_NL, 1'b0});
  endfunction

  // Folds one character into the line and queues the characters it emits.
  function automatic int fold_char(input logic [7:0] c);
    int unsigned col;
    int unsigned brk;
    int unsigned cut;
    int          base;
    base = folded_q.size();
    col = line_len;
    if (c == CH_TAB) begin
      do begin
        line_mem[col] = CH_BLANK;
        col++;
      end while (col < LW && (col % TS) != 0);
      if (col >= LW) begin
        emit_cols(LW);
        col = 0;
      end
    end else if (c == CH_NL) begin
      emit_cols(col);
      col = 0;
    end else begin
      line_mem[col] = c;
      col++;
      if (col >= LW) begin
        // A blank in column 0 is never a break point.
        brk = LW - 1;
        while (brk > 0 && line_mem[brk] != CH_BLANK) brk--;
        cut = (brk == 0) ? LW : brk + 1;
        emit_cols(cut);
        if (cut >= LW) begin
          col = 0;
        end else begin
          for (int i = 0; i < LW - cut; i++) line_mem[i] = line_mem[cut + i];
          col = LW - cut;
        end
      end
    end
    line_len = col;
    if (folded_q.size() > base) folded_q[folded_q.size() - 1].last = 1'b1;
    return folded_q.size() - base;
  endfunction

  function automatic logic [7:0] pick_ordinary();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      do c = 8'($urandom_range(0, 255));
      while (c == CH_TAB || c == CH_NL || c == CH_BLANK);
    end else begin
      c = 8'($urandom_range(33, 126));
    end
    return c;
  endfunction

  task automatic send_char(input logic [7:0] c, output int n_out);
    in_valid <= 1'b1;
    in_char  <= c;
    do @(posedge clk); while (in_stall);
    n_out = fold_char(c);
  endtask

  // Holds valid low for a random gap; most gaps are short, a few are long.
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = 0;
    if (steady_left > 0) begin
      steady_left--;
    end else if (r < 4) begin
      steady_left = $urandom_range(20, 60);
    end else if (r < 60) begin
      n = 0;
    end else if (r < 90) begin
      n = $urandom_range(1, 3);
    end else if (r < 97) begin
      n = $urandom_range(4, 12);
    end else begin
      n = $urandom_range(20, 60);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (folded_q.size() != 0);
  endtask

  always @(posedge clk) begin : stall_gen
    int r;
    r = $urandom_range(0, 99);
    if (quiet_left > 0) begin
      quiet_left <= quiet_left - 1;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (r < 3) begin
      quiet_left <= $urandom_range(20, 80);
      out_stall  <= 1'b0;
    end else if (r < 5) begin
      stall_left <= $urandom_range(10, 25);
      out_stall  <= 1'b1;
    end else if (r < 30) begin
      stall_left <= $urandom_range(0, 2);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : out_check
    folded_char_t want;
    if (!rst && out_valid && !out_stall) begin
      if (folded_q.size() == 0) begin
        $error("unexpected output item: out_char=%0h last_of_run=%0b",
               out_char, last_of_run);
        n_errors++;
      end else begin
        want = folded_q.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %0h, got %0h", want.ch, out_char);
          n_errors++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
          n_errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [7:0] text_q [$];
    int         n_out;
    int         r;
    int         len;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (text_tab[i]) begin
      send_char(text_tab[i].ch, n_out);
      if (text_tab[i].n_out >= 0 && n_out != text_tab[i].n_out) begin
        $error("output count for row %0d: expected %0d, got %0d",
               i, text_tab[i].n_out, n_out);
        n_errors++;
      end
      idle_gap();
    end
    drain();

    // Mostly well-formed text with random content, plus some noise.
    while (text_q.size() < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        len = $urandom_range(1, 9);
        repeat (len) text_q.push_back(pick_ordinary());
        r = $urandom_range(0, 99);
        if (r < 70) begin
          text_q.push_back(CH_BLANK);
        end else if (r < 82) begin
          text_q.push_back(CH_TAB);
        end else if (r < 92) begin
          text_q.push_back(CH_NL);
        end else begin
          text_q.push_back(CH_BLANK);
          text_q.push_back(CH_BLANK);
        end
      end else if (r < 80) begin
        // A word longer than the line has to be cut at full width.
        len = $urandom_range(LW + 1, LW + 13);
        repeat (len) text_q.push_back(pick_ordinary());
        text_q.push_back(CH_BLANK);
      end else if (r < 86) begin
        // The only blank of the line sits in column 0.
        text_q.push_back(CH_NL);
        text_q.push_back(CH_BLANK);
        len = $urandom_range(LW - 1, LW + 2);
        repeat (len) text_q.push_back(pick_ordinary());
      end else if (r < 92) begin
        text_q.push_back(CH_TAB);
        len = $urandom_range(1, 6);
        repeat (len) text_q.push_back(pick_ordinary());
      end else begin
        len = $urandom_range(4, 12);
        repeat (len) text_q.push_back(8'($urandom_range(0, 255)));
      end
    end

    foreach (text_q[i]) begin
      if (i == text_q.size() / 2) drain();
      send_char(text_q[i], n_out);
      idle_gap();
    end

    drain();
    repeat (2 * LW) @(posedge clk);
    if (n_errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #3_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
